>>> sv/id3p_pkg.sv
// id3p_pkg: shared types and constants for the ID3v2 tag frame parser.
// No dependencies; used by id3p_core and id3v2_frame_parser.
package id3p_pkg;

  localparam int unsigned HdrLen       = 10;  // bytes in a tag or frame header
  localparam int unsigned SizeBits     = 7;   // payload bits per synchsafe byte
  localparam int unsigned TagSizeFirst = 6;   // first tag size byte in the tag header
  localparam int unsigned IdBytes      = 4;   // identifier bytes in a frame header
  localparam int unsigned SizeLastIdx  = 8;   // frame size bytes run up to (not incl.) this
  localparam int unsigned SizeW        = 28;  // width of a decoded synchsafe size
  localparam int unsigned CntW         = 4;   // header byte counter width

  localparam logic KindHeader = 1'b0;
  localparam logic KindText   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic             kind;
    logic [31:0]      frame_id;
    logic [SizeW-1:0] frame_size;
    logic [7:0]       text_byte;
    logic             frame_end;
    logic             tag_end;
  } out_word_t;

endpackage

>>> sv/id3v2_frame_parser.sv
// id3v2_frame_parser: top level, byte input channel, parser core, two-entry output stage.
// Depends on id3p_pkg and id3p_core.
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_ready_o  in_data_i   (id3p_pkg::in_word_t)
//   out      out  out_valid_o/out_ready_i out_data_o (id3p_pkg::out_word_t)
//
// One byte is accepted per cycle while in_ready_o is high; any result is registered.
// The parser state updates at the accept edge; all per-byte work is one combinational pass.
// Output has a main register plus one skid entry, so in_ready_o comes from a flop only:
// input stalls only once both output entries are full.
// rst_ni is asynchronous, active low, and puts the parser at tag header byte 0.
// A word with stream_start set restarts the parser at any time.
module id3v2_frame_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  id3p_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output id3p_pkg::out_word_t out_data_o
);

  logic                accept;
  logic                res_valid;
  id3p_pkg::out_word_t res;

  id3p_pkg::out_word_t out_q, out_d;
  id3p_pkg::out_word_t skid_q, skid_d;
  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;

  // input is blocked only while the skid entry holds a word
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  id3p_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    logic push;
    logic pop;
    push         = accept && res_valid;
    pop          = out_valid_q && out_ready_i;
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      // main slot frees up: oldest word moves in
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while main entry empty");
  a_skid_drains_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && skid_valid_q) |=> (out_valid_q && out_q == $past(skid_q)))
    else $error("skid word not moved to output in order");
  a_no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("result dropped while output stalled");
`endif

endmodule

>>> sv/id3p_core.sv
// id3p_core: parser state and per-byte next-state / result logic.
// Depends on id3p_pkg.
module id3p_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  id3p_pkg::in_word_t   word_i,
  output logic                 res_valid_o,
  output id3p_pkg::out_word_t  res_o
);

  typedef enum logic [1:0] {
    PhTag,
    PhFhdr,
    PhData,
    PhDone
  } phase_e;

  localparam logic [id3p_pkg::CntW-1:0] CntLast =
    id3p_pkg::CntW'(id3p_pkg::HdrLen - 1);
  localparam logic [id3p_pkg::CntW-1:0] CntTagSize =
    id3p_pkg::CntW'(id3p_pkg::TagSizeFirst);
  localparam logic [id3p_pkg::CntW-1:0] CntIdEnd =
    id3p_pkg::CntW'(id3p_pkg::IdBytes);
  localparam logic [id3p_pkg::CntW-1:0] CntSizeEnd =
    id3p_pkg::CntW'(id3p_pkg::SizeLastIdx);
  localparam logic [id3p_pkg::SizeW-1:0] HdrLenW =
    id3p_pkg::SizeW'(id3p_pkg::HdrLen);
  localparam int unsigned SizeW = id3p_pkg::SizeW;
  localparam int unsigned SB    = id3p_pkg::SizeBits;

  phase_e                    phase_q, phase_d;
  logic [id3p_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [31:0]               id_q, id_d;
  logic [SizeW-1:0]          acc_q, acc_d;
  logic [SizeW-1:0]          tag_rem_q, tag_rem_d;
  logic [SizeW-1:0]          frm_rem_q, frm_rem_d;
  logic                      first_q, first_d;

  always_comb begin
    logic [7:0] b;
    logic       shown;
    b           = word_i.data_byte;
    shown       = 1'b0;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    id_d        = id_q;
    acc_d       = acc_q;
    tag_rem_d   = tag_rem_q;
    frm_rem_d   = frm_rem_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (word_i.stream_start) begin
      phase_d   = PhTag;
      cnt_d     = '0;
      id_d      = '0;
      acc_d     = '0;
      tag_rem_d = '0;
      frm_rem_d = '0;
      first_d   = 1'b0;
    end

    case (phase_d)
      PhTag: begin
        if (cnt_d == '0) acc_d = '0;
        if (cnt_d >= CntTagSize) acc_d = {acc_d[SizeW-SB-1:0], b[SB-1:0]};
        if (cnt_d >= CntLast) begin
          tag_rem_d = acc_d;
          cnt_d     = '0;
          phase_d   = (acc_d == '0) ? PhDone : PhFhdr;
        end else begin
          cnt_d = cnt_d + 1'b1;
        end
      end
      PhFhdr: begin
        if (cnt_d == '0) begin
          acc_d = '0;
          id_d  = '0;
        end
        if (cnt_d < CntIdEnd) begin
          id_d = {id_d[23:0], b};
        end else if (cnt_d < CntSizeEnd) begin
          acc_d = {acc_d[SizeW-SB-1:0], b[SB-1:0]};
        end
        if (cnt_d < CntLast) begin
          cnt_d = cnt_d + 1'b1;
        end else begin
          tag_rem_d = (tag_rem_d > HdrLenW) ? tag_rem_d - HdrLenW : '0;
          cnt_d     = '0;
          if (id_d == '0) begin
            // padding: nothing reported
            phase_d = (tag_rem_d == '0) ? PhDone : PhFhdr;
          end else begin
            frm_rem_d              = acc_d;
            res_valid_o            = 1'b1;
            res_o.kind             = id3p_pkg::KindHeader;
            res_o.frame_id         = id_d;
            res_o.frame_size       = acc_d;
            res_o.frame_end        = (acc_d <= SizeW'(1));
            res_o.tag_end          = (tag_rem_d == '0);
            if (acc_d == '0) begin
              first_d = 1'b0;
              phase_d = (tag_rem_d == '0) ? PhDone : PhFhdr;
            end else begin
              first_d = 1'b1;
              phase_d = PhData;
            end
          end
        end
      end
      PhData: begin
        // encoding byte is swallowed
        shown     = !first_d;
        first_d   = 1'b0;
        frm_rem_d = (frm_rem_d != '0) ? frm_rem_d - 1'b1 : '0;
        tag_rem_d = (tag_rem_d != '0) ? tag_rem_d - 1'b1 : '0;
        if (shown) begin
          res_valid_o      = 1'b1;
          res_o.kind       = id3p_pkg::KindText;
          res_o.frame_id   = id_d;
          res_o.frame_size = acc_d;
          res_o.text_byte  = b;
          res_o.frame_end  = (frm_rem_d == '0);
          res_o.tag_end    = (tag_rem_d == '0);
        end
        if (frm_rem_d == '0) begin
          cnt_d   = '0;
          phase_d = (tag_rem_d == '0) ? PhDone : PhFhdr;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhTag;
      cnt_q     <= '0;
      id_q      <= '0;
      acc_q     <= '0;
      tag_rem_q <= '0;
      frm_rem_q <= '0;
      first_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      id_q      <= id_d;
      acc_q     <= acc_d;
      tag_rem_q <= tag_rem_d;
      frm_rem_q <= frm_rem_d;
      first_q   <= first_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast)
    else $error("header byte counter out of range");
  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (frm_rem_q != '0))
    else $error("data phase with no frame bytes left");
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !word_i.stream_start) |-> !res_valid_o)
    else $error("result produced after end of tag");
  a_pending_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> (phase_q == PhData))
    else $error("encoding byte pending outside data phase");
`endif

endmodule
